[rtl/vpdc_pkg.sv]
package vpdc_pkg;

    typedef struct packed {
        logic signed [31:0] path_distance;
        logic signed [31:0] altitude;
        logic               hard_window;
        logic               final_sample;
    } t_in;

    typedef struct packed {
        logic signed [31:0] slope;
        logic [30:0]        speed_cap;
        logic [30:0]        accel_cap;
        logic [30:0]        jerk_cap;
        logic [3:0]         cap_flags;
        logic               constraint_active;
        logic               run_end;
        logic [30:0]        peak_slope;
        logic [30:0]        peak_curvature;
        logic [30:0]        peak_jerk;
        logic [30:0]        lowest_cap;
    } t_out;

    // divider: numerator left-aligned in DIV_W bits, CNT bits consumed
    localparam int DIV_W  = 74;
    localparam int ROOT_W = 28;

    localparam logic [6:0] CNT_DERIV = 7'd49;
    localparam logic [6:0] CNT_SPEED = 7'd39;
    localparam logic [6:0] CNT_ACCEL = 7'd55;
    localparam logic [6:0] CNT_JERK  = 7'd74;

    localparam logic [4:0] SQRT_TOP_BIT = 5'd27;
    localparam logic [4:0] CBRT_TOP_BIT = 5'd24;

    localparam logic [22:0] SPEED_LIM_MAX = 23'd6553600;
    localparam logic [25:0] JERK_LIM_MAX  = 26'd65536000;

    localparam logic [1:0] REG_CLIMB   = 2'd0;
    localparam logic [1:0] REG_DESCENT = 2'd1;
    localparam logic [1:0] REG_ACCEL   = 2'd2;
    localparam logic [1:0] REG_JERK    = 2'd3;

    function automatic logic [31:0] mag32(input logic signed [31:0] x);
        mag32 = x[31] ? (32'd0 - 32'(x)) : 32'(x);
    endfunction

    function automatic logic [30:0] sat31(input logic [31:0] x);
        sat31 = x[31] ? 31'h7FFF_FFFF : x[30:0];
    endfunction

endpackage

[rtl/vertical_profile_derivative_caps.sv]
// Vertical profile derivative and speed-cap unit. Takes one path sample per
// item and returns slope, curvature-based and jerk-based speed caps for the
// sample three places back; the final sample flushes the remaining results
// (up to four) and the last one carries run-wide peaks and the lowest cap.
// All math runs on one shared bit-serial divider (one quotient bit a cycle,
// 39 to 74 bits) and a bit-serial root unit (one result bit per pass: for
// square root a squaring and a compare, for cube root a squaring, two
// multiply halves and a compare). Derivative steps whose spacing is not
// positive and cap steps with a zero divisor are skipped, and a result waits
// while the one before it is held by i_stall. The block takes no new item
// until the current one is done.
module vertical_profile_derivative_caps (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  vpdc_pkg::t_in        i_item,
    output logic                 o_valid,
    input  logic                 i_stall,
    output vpdc_pkg::t_out       o_item,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [25:0]          i_cfg_data
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SL1  = 4'd1;
    localparam logic [3:0] ST_SL0  = 4'd2;
    localparam logic [3:0] ST_CV2  = 4'd3;
    localparam logic [3:0] ST_CV1  = 4'd4;
    localparam logic [3:0] ST_JK   = 4'd5;
    localparam logic [3:0] ST_SC   = 4'd6;
    localparam logic [3:0] ST_AC   = 4'd7;
    localparam logic [3:0] ST_AR   = 4'd8;
    localparam logic [3:0] ST_JC   = 4'd9;
    localparam logic [3:0] ST_JR   = 4'd10;
    localparam logic [3:0] ST_OUT  = 4'd11;
    localparam logic [3:0] ST_UPD  = 4'd12;

    logic [22:0] r_climb, r_descent, r_accel;
    logic [25:0] r_jerk;

    // path state
    logic signed [31:0] r_dw [4];
    logic signed [31:0] r_aw [2];
    logic               r_fw [3];
    logic signed [31:0] r_slw [2];
    logic signed [31:0] r_cvw [2];
    logic [2:0]         r_m;
    logic [30:0]        r_pk_sl, r_pk_cv, r_pk_jk, r_min;
    logic               r_minv;

    // working values of the current item
    logic [3:0]         r_state;
    logic               r_busy;
    logic signed [31:0] r_s0, r_z0;
    logic               r_h0, r_fin;
    logic signed [31:0] r_sl0, r_sl1, r_cv1, r_cv2, r_jk;
    logic [30:0]        r_sc, r_ac, r_jc;
    logic [1:0]         r_k;
    logic               r_ovalid;
    vpdc_pkg::t_out     r_out;

    logic                               div_start, div_done;
    logic [vpdc_pkg::DIV_W-1:0]         div_num, div_quo;
    logic [31:0]                        div_den;
    logic [6:0]                         div_cnt;
    logic                               root_start, root_done, root_cube;
    logic [vpdc_pkg::ROOT_W-1:0]        root_val;

    logic signed [31:0] d_a, d_b, d_sn, d_sp;
    logic signed [32:0] d_diff, d_ds;
    logic [32:0]        d_mag;
    logic               d_pos, d_need, d_go, d_fin;
    logic signed [31:0] d_res, d_val;

    logic signed [31:0] e_sl, e_cv;
    logic               e_h, e_last;
    logic [22:0]        lim_s, lim_a, lim_sel;
    logic [25:0]        lim_j;
    logic               c_need;
    logic [30:0]        sc_sat;
    logic               note_en;
    logic [30:0]        note_val;
    logic [30:0]        nx_pk_sl, nx_pk_cv, nx_pk_jk;
    logic [1:0]         k_first;
    logic [3:0]         flags;

    vpdc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_cnt   (div_cnt),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    vpdc_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (root_start),
        .i_q     (div_quo),
        .i_cube  (root_cube),
        .o_done  (root_done),
        .o_root  (root_val)
    );

    // operands of the derivative step in progress
    always_comb begin
        d_a    = '0;
        d_b    = '0;
        d_sn   = '0;
        d_sp   = '0;
        d_need = 1'b0;
        unique case (r_state)
            ST_SL1: begin
                d_a    = r_z0;
                d_b    = (r_m >= 3'd2) ? r_aw[1] : r_aw[0];
                d_sn   = r_s0;
                d_sp   = (r_m >= 3'd2) ? r_dw[1] : r_dw[0];
                d_need = r_m >= 3'd1;
            end
            ST_SL0: begin
                d_a    = r_z0;
                d_b    = r_aw[0];
                d_sn   = r_s0;
                d_sp   = r_dw[0];
                d_need = r_fin && r_m >= 3'd1;
            end
            ST_CV2: begin
                d_a    = r_sl1;
                d_b    = r_slw[1];
                d_sn   = r_dw[0];
                d_sp   = r_dw[2];
                d_need = r_m >= 3'd3;
            end
            ST_CV1: begin
                d_a    = r_sl0;
                d_b    = r_slw[0];
                d_sn   = r_s0;
                d_sp   = r_dw[1];
                d_need = r_fin && r_m >= 3'd2;
            end
            ST_JK: begin
                unique case (r_k)
                    2'd1: begin
                        d_a  = '0;
                        d_b  = r_cv2;
                        d_sn = r_s0;
                        d_sp = r_dw[1];
                    end
                    2'd2: begin
                        d_a  = r_cv1;
                        d_b  = r_cvw[0];
                        d_sn = r_dw[0];
                        d_sp = r_dw[2];
                    end
                    2'd3: begin
                        d_a  = r_cv2;
                        d_b  = r_cvw[1];
                        d_sn = r_dw[1];
                        d_sp = r_dw[3];
                    end
                    default: begin
                        d_a  = '0;
                        d_b  = '0;
                        d_sn = '0;
                        d_sp = '0;
                    end
                endcase
                d_need = r_k != 2'd0 && r_m > {1'b0, r_k};
            end
            default: d_need = 1'b0;
        endcase
    end

    assign d_diff = 33'(d_a) - 33'(d_b);
    assign d_ds   = 33'(d_sn) - 33'(d_sp);
    assign d_pos  = !d_ds[32] && d_ds != '0;
    assign d_mag  = d_diff[32] ? (33'd0 - 33'(d_diff)) : 33'(d_diff);

    always_comb begin
        if (!d_diff[32]) begin
            d_res = (div_quo > 74'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(div_quo[31:0]);
        end else begin
            d_res = (div_quo >= 74'h8000_0000) ? 32'sh8000_0000
                                               : $signed(32'd0 - div_quo[31:0]);
        end
    end

    assign d_go  = d_need && !r_busy && d_pos;
    assign d_fin = !d_need || (!r_busy && !d_pos) || (r_busy && div_done);
    assign d_val = (d_need && r_busy) ? d_res : 32'sd0;

    // values of the result being assembled
    always_comb begin
        unique case (r_k)
            2'd0: begin
                e_sl = r_sl0;
                e_cv = '0;
                e_h  = r_h0;
            end
            2'd1: begin
                e_sl = r_sl1;
                e_cv = r_cv1;
                e_h  = r_fw[0];
            end
            2'd2: begin
                e_sl = r_slw[0];
                e_cv = r_cv2;
                e_h  = r_fw[1];
            end
            default: begin
                e_sl = r_slw[1];
                e_cv = r_cvw[0];
                e_h  = r_fw[2];
            end
        endcase
    end

    assign e_last = r_fin && r_k == 2'd0;

    assign lim_sel = (e_sl[31]) ? r_descent : r_climb;
    assign lim_s = (lim_sel == '0) ? 23'd1 :
                   (lim_sel > vpdc_pkg::SPEED_LIM_MAX) ? vpdc_pkg::SPEED_LIM_MAX : lim_sel;
    assign lim_a = (r_accel == '0) ? 23'd1 :
                   (r_accel > vpdc_pkg::SPEED_LIM_MAX) ? vpdc_pkg::SPEED_LIM_MAX : r_accel;
    assign lim_j = (r_jerk == '0) ? 26'd1 :
                   (r_jerk > vpdc_pkg::JERK_LIM_MAX) ? vpdc_pkg::JERK_LIM_MAX : r_jerk;

    assign sc_sat = (div_quo > 74'h7FFF_FFFF) ? 31'h7FFF_FFFF : div_quo[30:0];

    always_comb begin
        c_need = 1'b0;
        unique case (r_state)
            ST_SC:   c_need = e_sl != '0;
            ST_AC:   c_need = e_cv != '0;
            ST_JC:   c_need = r_jk != '0;
            default: c_need = 1'b0;
        endcase
    end

    // shared divider request
    always_comb begin
        div_start = 1'b0;
        div_num   = {d_mag, 41'd0};
        div_den   = d_ds[31:0];
        div_cnt   = vpdc_pkg::CNT_DERIV;
        unique case (r_state)
            ST_SL1, ST_SL0, ST_CV2, ST_CV1, ST_JK: div_start = d_go;
            ST_SC: begin
                div_start = c_need && !r_busy;
                div_num   = {lim_s, 51'd0};
                div_den   = vpdc_pkg::mag32(e_sl);
                div_cnt   = vpdc_pkg::CNT_SPEED;
            end
            ST_AC: begin
                div_start = c_need && !r_busy;
                div_num   = {lim_a, 51'd0};
                div_den   = vpdc_pkg::mag32(e_cv);
                div_cnt   = vpdc_pkg::CNT_ACCEL;
            end
            ST_JC: begin
                div_start = c_need && !r_busy;
                div_num   = {lim_j, 48'd0};
                div_den   = vpdc_pkg::mag32(r_jk);
                div_cnt   = vpdc_pkg::CNT_JERK;
            end
            default: div_start = 1'b0;
        endcase
    end

    assign root_start = (r_state == ST_AC || r_state == ST_JC) && r_busy && div_done;
    assign root_cube  = r_state == ST_JC;

    always_comb begin
        note_en  = 1'b0;
        note_val = '0;
        if (r_state == ST_SC && r_busy && div_done) begin
            note_en  = 1'b1;
            note_val = sc_sat;
        end else if ((r_state == ST_AR || r_state == ST_JR) && root_done) begin
            note_en  = 1'b1;
            note_val = 31'(root_val);
        end
    end

    always_comb begin
        logic [30:0] m_sl, m_cv, m_jk;
        m_sl = vpdc_pkg::sat31(vpdc_pkg::mag32(e_sl));
        m_cv = vpdc_pkg::sat31(vpdc_pkg::mag32(e_cv));
        m_jk = vpdc_pkg::sat31(vpdc_pkg::mag32(r_jk));
        nx_pk_sl = (m_sl > r_pk_sl) ? m_sl : r_pk_sl;
        nx_pk_cv = (m_cv > r_pk_cv) ? m_cv : r_pk_cv;
        nx_pk_jk = (m_jk > r_pk_jk) ? m_jk : r_pk_jk;
    end

    assign flags   = {e_last && r_minv, r_jk != '0, e_cv != '0, e_sl != '0};
    assign k_first = (r_fin && r_m < 3'd3) ? r_m[1:0] : 2'd3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_climb   <= 23'd209715;
            r_descent <= 23'd209715;
            r_accel   <= 23'd196608;
            r_jerk    <= 26'd589824;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vpdc_pkg::REG_CLIMB:   r_climb   <= i_cfg_data[22:0];
                vpdc_pkg::REG_DESCENT: r_descent <= i_cfg_data[22:0];
                vpdc_pkg::REG_ACCEL:   r_accel   <= i_cfg_data[22:0];
                vpdc_pkg::REG_JERK:    r_jerk    <= i_cfg_data;
                default:               r_jerk    <= r_jerk;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
            r_k      <= '0;
            r_m      <= '0;
            r_pk_sl  <= '0;
            r_pk_cv  <= '0;
            r_pk_jk  <= '0;
            r_min    <= '0;
            r_minv   <= 1'b0;
            for (int i = 0; i < 4; i++) r_dw[i] <= '0;
            for (int i = 0; i < 2; i++) begin
                r_aw[i]  <= '0;
                r_slw[i] <= '0;
                r_cvw[i] <= '0;
            end
            for (int i = 0; i < 3; i++) r_fw[i] <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;

            if (note_en && (!r_minv || note_val < r_min)) begin
                r_min  <= note_val;
                r_minv <= 1'b1;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_s0    <= i_item.path_distance;
                        r_z0    <= i_item.altitude;
                        r_h0    <= i_item.hard_window;
                        r_fin   <= i_item.final_sample;
                        r_sl0   <= '0;
                        r_sl1   <= '0;
                        r_cv1   <= '0;
                        r_cv2   <= '0;
                        r_state <= ST_SL1;
                    end
                end
                ST_SL1, ST_SL0, ST_CV2, ST_CV1, ST_JK: begin
                    if (d_go) r_busy <= 1'b1;
                    if (d_fin) begin
                        r_busy <= 1'b0;
                        unique case (r_state)
                            ST_SL1: begin
                                r_sl1   <= d_val;
                                r_state <= ST_SL0;
                            end
                            ST_SL0: begin
                                r_sl0   <= d_val;
                                r_state <= ST_CV2;
                            end
                            ST_CV2: begin
                                r_cv2   <= d_val;
                                r_state <= ST_CV1;
                            end
                            ST_CV1: begin
                                r_cv1 <= d_val;
                                r_k   <= k_first;
                                r_state <= (r_fin || r_m >= 3'd3) ? ST_JK : ST_UPD;
                            end
                            default: begin
                                r_jk    <= d_val;
                                r_state <= ST_SC;
                            end
                        endcase
                    end
                end
                ST_SC: begin
                    if (!c_need) begin
                        r_sc    <= '0;
                        r_state <= ST_AC;
                    end else if (!r_busy) begin
                        r_busy <= 1'b1;
                    end else if (div_done) begin
                        r_sc    <= sc_sat;
                        r_busy  <= 1'b0;
                        r_state <= ST_AC;
                    end
                end
                ST_AC: begin
                    if (!c_need) begin
                        r_ac    <= '0;
                        r_state <= ST_JC;
                    end else if (!r_busy) begin
                        r_busy <= 1'b1;
                    end else if (div_done) begin
                        r_busy  <= 1'b0;
                        r_state <= ST_AR;
                    end
                end
                ST_AR: begin
                    if (root_done) begin
                        r_ac    <= 31'(root_val);
                        r_state <= ST_JC;
                    end
                end
                ST_JC: begin
                    if (!c_need) begin
                        r_jc    <= '0;
                        r_state <= ST_OUT;
                    end else if (!r_busy) begin
                        r_busy <= 1'b1;
                    end else if (div_done) begin
                        r_busy  <= 1'b0;
                        r_state <= ST_JR;
                    end
                end
                ST_JR: begin
                    if (root_done) begin
                        r_jc    <= 31'(root_val);
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!r_ovalid) begin
                        r_out.slope             <= e_sl;
                        r_out.speed_cap         <= r_sc;
                        r_out.accel_cap         <= r_ac;
                        r_out.jerk_cap          <= r_jc;
                        r_out.cap_flags         <= flags;
                        r_out.constraint_active <= e_h || flags[2:0] != 3'd0;
                        r_out.run_end           <= e_last;
                        r_out.peak_slope        <= e_last ? nx_pk_sl : 31'd0;
                        r_out.peak_curvature    <= e_last ? nx_pk_cv : 31'd0;
                        r_out.peak_jerk         <= e_last ? nx_pk_jk : 31'd0;
                        r_out.lowest_cap        <= (e_last && r_minv) ? r_min : 31'd0;
                        r_ovalid <= 1'b1;
                        r_pk_sl  <= nx_pk_sl;
                        r_pk_cv  <= nx_pk_cv;
                        r_pk_jk  <= nx_pk_jk;
                        if (r_k == (r_fin ? 2'd0 : 2'd3)) begin
                            r_state <= ST_UPD;
                        end else begin
                            r_k     <= r_k - 2'd1;
                            r_state <= ST_JK;
                        end
                    end
                end
                ST_UPD: begin
                    if (r_fin) begin
                        r_m     <= '0;
                        r_pk_sl <= '0;
                        r_pk_cv <= '0;
                        r_pk_jk <= '0;
                        r_min   <= '0;
                        r_minv  <= 1'b0;
                        for (int i = 0; i < 4; i++) r_dw[i] <= '0;
                        for (int i = 0; i < 2; i++) begin
                            r_aw[i]  <= '0;
                            r_slw[i] <= '0;
                            r_cvw[i] <= '0;
                        end
                        for (int i = 0; i < 3; i++) r_fw[i] <= 1'b0;
                    end else begin
                        r_dw[0]  <= r_s0;
                        r_dw[1]  <= r_dw[0];
                        r_dw[2]  <= r_dw[1];
                        r_dw[3]  <= r_dw[2];
                        r_aw[0]  <= r_z0;
                        r_aw[1]  <= r_aw[0];
                        r_fw[0]  <= r_h0;
                        r_fw[1]  <= r_fw[0];
                        r_fw[2]  <= r_fw[1];
                        r_slw[0] <= r_sl1;
                        r_slw[1] <= r_slw[0];
                        r_cvw[0] <= r_cv2;
                        r_cvw[1] <= r_cvw[0];
                        r_m      <= (r_m < 3'd4) ? r_m + 3'd1 : 3'd4;
                    end
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_stall = r_state != ST_IDLE;
    assign o_valid = r_ovalid;
    assign o_item  = r_out;

endmodule

[rtl/vpdc_div.sv]
module vpdc_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [vpdc_pkg::DIV_W-1:0]   i_num,
    input  logic [31:0]                  i_den,
    input  logic [6:0]                   i_cnt,
    output logic                         o_done,
    output logic [vpdc_pkg::DIV_W-1:0]   o_quo
);

    logic                         r_run;
    logic                         r_done;
    logic [6:0]                   r_cnt;
    logic [vpdc_pkg::DIV_W-1:0]   r_num;
    logic [vpdc_pkg::DIV_W-1:0]   r_quo;
    logic [31:0]                  r_rem;
    logic [31:0]                  r_den;
    logic [32:0]                  rem2;
    logic [32:0]                  rem_sub;
    logic                         ge;

    assign rem2    = {r_rem, r_num[vpdc_pkg::DIV_W-1]};
    assign ge      = rem2 >= {1'b0, r_den};
    assign rem_sub = rem2 - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= i_cnt;
                r_num <= i_num;
                r_den <= i_den;
                r_rem <= '0;
                r_quo <= '0;
            end else if (r_run) begin
                r_num <= {r_num[vpdc_pkg::DIV_W-2:0], 1'b0};
                r_rem <= ge ? rem_sub[31:0] : rem2[31:0];
                r_quo <= {r_quo[vpdc_pkg::DIV_W-2:0], ge};
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

[rtl/vpdc_root.sv]
module vpdc_root (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [vpdc_pkg::DIV_W-1:0]   i_q,
    input  logic                         i_cube,
    output logic                         o_done,
    output logic [vpdc_pkg::ROOT_W-1:0]  o_root
);

    logic                         r_run;
    logic                         r_done;
    logic                         r_cube;
    logic [1:0]                   r_phase;
    logic [4:0]                   r_bit;
    logic [vpdc_pkg::ROOT_W-1:0]  r_c;
    logic [vpdc_pkg::DIV_W-1:0]   r_q;
    logic [55:0]                  r_sq;
    logic [74:0]                  r_cb;
    logic [vpdc_pkg::ROOT_W-1:0]  trial;
    logic                         adv;
    logic                         keep;

    assign trial = r_c | (vpdc_pkg::ROOT_W'(1) << r_bit);

    always_comb begin
        adv  = 1'b0;
        keep = 1'b0;
        if (r_run) begin
            if (r_phase == 2'd1 && !r_cube) begin
                adv  = 1'b1;
                keep = 74'(r_sq) <= r_q;
            end else if (r_phase == 2'd3) begin
                adv  = 1'b1;
                keep = r_cb <= {1'b0, r_q};
            end
        end
    end

    // one result bit per pass: square of the trial, for a cube the square
    // times the trial in two halves, then compare
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run   <= 1'b1;
                r_cube  <= i_cube;
                r_q     <= i_q;
                r_c     <= '0;
                r_phase <= 2'd0;
                r_bit   <= i_cube ? vpdc_pkg::CBRT_TOP_BIT : vpdc_pkg::SQRT_TOP_BIT;
            end else if (r_run) begin
                if (r_phase == 2'd0) begin
                    r_sq    <= 56'(trial) * 56'(trial);
                    r_phase <= 2'd1;
                end else if (r_phase == 2'd1 && r_cube) begin
                    r_cb    <= {50'(r_sq[49:25]) * 50'(trial[24:0]), 25'd0};
                    r_phase <= 2'd2;
                end else if (r_phase == 2'd2) begin
                    r_cb    <= r_cb + 75'(50'(r_sq[24:0]) * 50'(trial[24:0]));
                    r_phase <= 2'd3;
                end
                if (adv) begin
                    if (keep) r_c <= trial;
                    r_phase <= 2'd0;
                    if (r_bit == 5'd0) begin
                        r_run  <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_bit <= r_bit - 5'd1;
                    end
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_c;

endmodule
